// ===== sv/set_assoc_cache_lru_lookup_top_assert.svh =====
// Assertion macros for the set-associative LRU lookup block.
// Included by the top level; define ASSERT_OFF to compile them out.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SALRU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SALRU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SALRU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SALRU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/salru_pkg.sv =====
// Shared widths, register indexes and struct types for the LRU lookup block.
// No dependencies.
package salru_pkg;

	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned TAG_W      = 32;
	localparam int unsigned STAMP_W    = 32;
	localparam int unsigned CNT_W      = 32;
	localparam int unsigned OFF_W      = 5;
	localparam int unsigned SETB_W     = 2;
	localparam int unsigned WAY_OUT_W  = 2;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 1'b1;

	localparam logic [OFF_W-1:0]  OFFSET_BITS_RST = 5'd4;
	localparam logic [SETB_W-1:0] SET_BITS_RST    = 2'd0;

	// decoded request handed to the lookup engine
	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [SETB_W-1:0] set;
		logic [SETB_W-1:0] set_bits;
	} lookup_t;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way_used;
		logic [CNT_W-1:0]     hit_count;
		logic [CNT_W-1:0]     miss_count;
	} result_t;

	typedef struct packed {
		logic idle;
		logic load;
	} status_t;

endpackage

// ===== sv/salru_if.sv =====
// Channel interfaces: request, result and configuration write.
// Depends on salru_pkg.
interface salru_req_if;
	import salru_pkg::*;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] address;
	modport source (output valid, output address, input ready);
	modport sink (input valid, input address, output ready);
endinterface

interface salru_rsp_if;
	import salru_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [WAY_OUT_W-1:0] way_used;
	logic [CNT_W-1:0]     hit_count;
	logic [CNT_W-1:0]     miss_count;
	modport source (output valid, output hit, output way_used, output hit_count,
		output miss_count, input ready);
	modport sink (input valid, input hit, input way_used, input hit_count,
		input miss_count, output ready);
endinterface

interface salru_cfg_if;
	import salru_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/salru_ram.sv =====
// Tag/stamp line store: one write port, one read port, registered read data.
// No dependencies.
module salru_ram #(
	parameter int unsigned DEPTH = 4,
	parameter int unsigned WIDTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/salru_ctrl.sv =====
// Lookup engine: walks the ways of a set through the line store, picks the
// hit, fill or LRU victim, writes back and holds the result. Uses salru_pkg, salru_ram.
module salru_ctrl #(
	parameter int unsigned LINES = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  salru_pkg::lookup_t lk,
	output salru_pkg::status_t status,
	output logic              res_valid,
	input  logic              res_ready,
	output salru_pkg::result_t res
);
	import salru_pkg::*;

	localparam int unsigned LW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int unsigned WW = $clog2(LINES + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WB} state_t;

	state_t               state_q;
	logic [TAG_W-1:0]     tag_q;
	logic [LW-1:0]        base_q;
	logic [WW-1:0]        ways_q;
	logic [WW-1:0]        cnt_q;
	logic                 cmp_v_s1;
	logic [WW-1:0]        cmp_way_s1;
	logic [LW-1:0]        cmp_line_s1;
	logic                 hit_found_q;
	logic [WW-1:0]        hit_way_q;
	logic                 inv_found_q;
	logic [WW-1:0]        inv_way_q;
	logic [STAMP_W-1:0]   best_stamp_q;
	logic [WW-1:0]        best_way_q;
	logic [STAMP_W-1:0]   clock_q;
	logic [CNT_W-1:0]     hits_q;
	logic [CNT_W-1:0]     misses_q;
	logic [LINES-1:0]     valid_q;
	result_t              res_q;
	logic                 res_valid_q;

	logic [WW-1:0]              ways_new;
	logic [WW+1:0]              base_full;
	logic                       rd_en;
	logic [LW-1:0]              rd_line;
	logic [TAG_W+STAMP_W-1:0]   rd_data;
	logic [TAG_W-1:0]           rd_tag;
	logic [STAMP_W-1:0]         rd_stamp;
	logic                       cur_valid;
	logic                       cmp_last;
	logic                       go;
	logic [WW-1:0]              fin_way;
	logic [LW-1:0]              wr_line;

	assign ways_new  = WW'(LINES >> lk.set_bits);
	assign base_full = (WW + 2)'(lk.set) * (WW + 2)'(ways_new);

	assign rd_en   = (state_q == S_SCAN) && (cnt_q < ways_q);
	assign rd_line = LW'((WW + 1)'(base_q) + (WW + 1)'(cnt_q));

	salru_ram #(
		.DEPTH(LINES),
		.WIDTH(TAG_W + STAMP_W)
	) u_ram (
		.clk    (clk),
		.wr_en  (go),
		.wr_addr(wr_line),
		.wr_data({tag_q, clock_q}),
		.rd_en  (rd_en),
		.rd_addr(rd_line),
		.rd_data(rd_data)
	);

	assign rd_tag    = rd_data[TAG_W+STAMP_W-1:STAMP_W];
	assign rd_stamp  = rd_data[STAMP_W-1:0];
	assign cur_valid = valid_q[cmp_line_s1];
	assign cmp_last  = cmp_v_s1 && (cmp_way_s1 == ways_q - WW'(1));

	assign go      = (state_q == S_WB) && (!res_valid_q || res_ready);
	assign fin_way = hit_found_q ? hit_way_q : (inv_found_q ? inv_way_q : best_way_q);
	assign wr_line = LW'((WW + 1)'(base_q) + (WW + 1)'(fin_way));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tag_q        <= '0;
			base_q       <= '0;
			ways_q       <= '0;
			cnt_q        <= '0;
			cmp_v_s1     <= 1'b0;
			cmp_way_s1   <= '0;
			cmp_line_s1  <= '0;
			hit_found_q  <= 1'b0;
			hit_way_q    <= '0;
			inv_found_q  <= 1'b0;
			inv_way_q    <= '0;
			best_stamp_q <= '0;
			best_way_q   <= '0;
			clock_q      <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
			valid_q      <= '0;
			res_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			cmp_v_s1    <= rd_en;
			cmp_way_s1  <= cnt_q;
			cmp_line_s1 <= rd_line;
			if (go) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						tag_q       <= lk.tag;
						base_q      <= LW'(base_full);
						ways_q      <= ways_new;
						cnt_q       <= '0;
						clock_q     <= clock_q + STAMP_W'(1);
						hit_found_q <= 1'b0;
						hit_way_q   <= '0;
						inv_found_q <= 1'b0;
						inv_way_q   <= '0;
						best_way_q  <= '0;
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + WW'(1);
					end
					if (cmp_v_s1) begin
						// lowest valid match wins
						if (!hit_found_q && cur_valid && rd_tag == tag_q) begin
							hit_found_q <= 1'b1;
							hit_way_q   <= cmp_way_s1;
						end
						if (!inv_found_q && !cur_valid) begin
							inv_found_q <= 1'b1;
							inv_way_q   <= cmp_way_s1;
						end
						// strict less-than keeps the lowest of equal stamps
						if (cmp_way_s1 == '0 || rd_stamp < best_stamp_q) begin
							best_stamp_q <= rd_stamp;
							best_way_q   <= cmp_way_s1;
						end
						if (cmp_last) begin
							state_q <= S_WB;
						end
					end
				end
				S_WB: begin
					if (go) begin
						valid_q[wr_line] <= 1'b1;
						res_q.hit        <= hit_found_q;
						res_q.way_used   <= WAY_OUT_W'(fin_way);
						if (hit_found_q) begin
							hits_q           <= hits_q + CNT_W'(1);
							res_q.hit_count  <= hits_q + CNT_W'(1);
							res_q.miss_count <= misses_q;
						end else begin
							misses_q         <= misses_q + CNT_W'(1);
							res_q.hit_count  <= hits_q;
							res_q.miss_count <= misses_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign status.idle = (state_q == S_IDLE);
	assign status.load = go;
	assign res_valid   = res_valid_q;
	assign res         = res_q;

endmodule

// ===== sv/set_assoc_cache_lru_lookup_top.sv =====
// Top level of the set-associative LRU cache tag lookup: config registers,
// address split and the lookup engine. Uses salru_pkg, salru_if, salru_ctrl.
//
// One address goes in per lookup and one result comes out: hit flag, way
// within the set, and running hit and miss counts (32-bit, wrapping). Tags
// and use stamps sit in a LINES-deep single-port-read RAM, one line per
// entry; valid bits are flops cleared by reset, so no clearing pass is
// needed. The engine reads one way of the set per cycle from that RAM;
// a set has ways = LINES >> s, s being the set-bit register clamped to 2
// and to 2^s <= LINES. An address is accepted only once the last lookup
// has written back, which waits while an older result is not yet taken;
// the next address is accepted while a finished result still waits in the
// output register. Write configuration only while no lookup is in flight.
`include "set_assoc_cache_lru_lookup_top_assert.svh"

module set_assoc_cache_lru_lookup_top #(
	parameter int unsigned LINES     = 4,
	parameter int unsigned ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	salru_cfg_if.sink   cfg,
	salru_req_if.sink   req,
	salru_rsp_if.source rsp
);
	import salru_pkg::*;

	localparam int unsigned EFF_W = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
	localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << EFF_W) - 64'd1);

	logic [OFF_W-1:0]  offset_q;
	logic [SETB_W-1:0] set_bits_q;
	logic [SETB_W-1:0] sb_eff;
	logic [ADDR_W-1:0] addr_m;
	logic [ADDR_W-1:0] addr_sh;
	logic [SETB_W-1:0] set_mask;
	lookup_t           lk;
	status_t           status;
	result_t           res;
	logic              res_valid;
	logic              start;

	// config port never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= OFFSET_BITS_RST;
			set_bits_q <= SET_BITS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_OFFSET_BITS: offset_q   <= cfg.data[OFF_W-1:0];
				CFG_SET_BITS:    set_bits_q <= cfg.data[SETB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// set bits clamp to 2, then down until the sets fit in LINES
	always_comb begin
		sb_eff = '0;
		if (set_bits_q >= 2'd2 && LINES >= 4) begin
			sb_eff = 2'd2;
		end else if (set_bits_q >= 2'd1 && LINES >= 2) begin
			sb_eff = 2'd1;
		end
	end

	assign addr_m   = req.address & ADDR_MASK;
	assign addr_sh  = addr_m >> offset_q;
	assign set_mask = SETB_W'((3'd1 << sb_eff) - 3'd1);

	assign lk.set      = addr_sh[SETB_W-1:0] & set_mask;
	assign lk.tag      = addr_m >> (6'(offset_q) + 6'(sb_eff));
	assign lk.set_bits = sb_eff;

	assign req.ready = status.idle;
	assign start     = req.valid && status.idle;

	salru_ctrl #(
		.LINES(LINES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.lk       (lk),
		.status   (status),
		.res_valid(res_valid),
		.res_ready(rsp.ready),
		.res      (res)
	);

	assign rsp.valid      = res_valid;
	assign rsp.hit        = res.hit;
	assign rsp.way_used   = res.way_used;
	assign rsp.hit_count  = res.hit_count;
	assign rsp.miss_count = res.miss_count;

	`SALRU_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready,
		!req.ready && !status.load, "lookup engine not busy after accept")
	`SALRU_ASSERT_IMP(a_load_while_busy, clk, arst_n, status.load, !req.ready,
		"result loaded while engine idle")
	`SALRU_ASSERT_NXT(a_load_gives_result, clk, arst_n, status.load, rsp.valid,
		"loaded result not presented")

endmodule
